FILE: hdl/vub_pkg.sv
`timescale 1ns / 1ps
// vu meter ballistics package: widths, command codes, register indexes, types
// used by every file of the block; depends on nothing

package vub_pkg;

  localparam int NUM_CHANNELS = 64;
  localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHAN_W       = 6;
  localparam int LEVEL_W      = 24;
  localparam int ALPHA_W      = 17;
  localparam int ALPHA_FRAC   = 16;
  localparam int PROD_W       = LEVEL_W + ALPHA_W;
  localparam int REG_IDX_W    = 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 1'd1;

  typedef enum logic [1:0] {
    CMD_SMOOTH = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_HOLD   = 2'd2
  } vub_cmd_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] peak;
  } vub_wr_t;

endpackage

FILE: hdl/vub_track.sv
`timescale 1ns / 1ps
// one attack/release step: prev moved toward cur by alpha, floor of the scaled step
// depends on vub_pkg

module vub_track (
  input  logic [vub_pkg::LEVEL_W-1:0] prev,
  input  logic [vub_pkg::LEVEL_W-1:0] cur,
  input  logic [vub_pkg::ALPHA_W-1:0] alpha,
  output logic [vub_pkg::LEVEL_W-1:0] next
);
  import vub_pkg::*;

  logic               rising;
  logic [LEVEL_W-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_up;
  logic [LEVEL_W-1:0] step;

  assign rising  = (cur >= prev);
  assign mag     = rising ? (cur - prev) : (prev - cur);
  assign prod    = PROD_W'(alpha) * PROD_W'(mag);
  // falling side rounds the magnitude up so the signed step floors
  assign prod_up = prod + PROD_W'((1 << ALPHA_FRAC) - 1);
  assign step    = rising ? prod[ALPHA_FRAC +: LEVEL_W] : prod_up[ALPHA_FRAC +: LEVEL_W];
  assign next    = rising ? (prev + step) : (prev - step);

endmodule

FILE: hdl/vub_store.sv
`timescale 1ns / 1ps
// per-channel rms and peak stores: synchronous memories, valid bits, write forwarding
// depends on vub_pkg

module vub_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [vub_pkg::ADDR_W-1:0]  rd_addr,
  input  vub_pkg::vub_wr_t            wr,
  output logic [vub_pkg::LEVEL_W-1:0] old_rms,
  output logic [vub_pkg::LEVEL_W-1:0] old_peak
);
  import vub_pkg::*;

  logic [LEVEL_W-1:0]      rms_mem [NUM_CHANNELS];
  logic [LEVEL_W-1:0]      peak_mem [NUM_CHANNELS];
  logic [LEVEL_W-1:0]      rd_rms_r;
  logic [LEVEL_W-1:0]      rd_peak_r;
  logic [ADDR_W-1:0]       rd_addr_r;
  logic [NUM_CHANNELS-1:0] vld_r;
  logic                    fwd_en_r;
  vub_wr_t                 fwd_r;
  logic                    fwd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rms_mem[wr.addr]  <= wr.rms;
      peak_mem[wr.addr] <= wr.peak;
    end
    if (rd_en) begin
      rd_rms_r  <= rms_mem[rd_addr];
      rd_peak_r <= peak_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // last write, covers a read that sampled the array at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      fwd_en_r <= 1'b0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
      fwd_en_r       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_r <= wr;
    end
  end

  assign fwd_hit = fwd_en_r && (fwd_r.addr == rd_addr_r);

  always_comb begin
    if (fwd_hit) begin
      old_rms  = fwd_r.rms;
      old_peak = fwd_r.peak;
    end else if (vld_r[rd_addr_r]) begin
      old_rms  = rd_rms_r;
      old_peak = rd_peak_r;
    end else begin
      old_rms  = '0;
      old_peak = '0;
    end
  end

endmodule

FILE: hdl/vu_meter_ballistics.sv
`timescale 1ns / 1ps
// vu meter ballistics top level: config registers, read-modify-write pipeline, result register
// depends on vub_pkg, vub_store, vub_track
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | in_cmd, in_channel, in_rms_level, in_peak_level
//   out     | out_valid/out_stall| out_channel, out_smoothed_rms, out_smoothed_peak
//   cfg     | cfg_we             | cfg_addr, cfg_wdata
//
// one transfer per cycle unless stalled; items pass the update stage, then the result register
// the store read issues at accept, update and write back as the item leaves the update stage
// back-to-back items on one channel use the forwarded last write
// reset clears the valid bits, no clearing pass; alphas reset to one
// out_stall with a pending result holds the update stage and raises in_stall in the same cycle

module vu_meter_ballistics (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [vub_pkg::CHAN_W-1:0]        in_channel,
  input  logic [vub_pkg::LEVEL_W-1:0]       in_rms_level,
  input  logic [vub_pkg::LEVEL_W-1:0]       in_peak_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vub_pkg::CHAN_W-1:0]        out_channel,
  output logic [vub_pkg::LEVEL_W-1:0]       out_smoothed_rms,
  output logic [vub_pkg::LEVEL_W-1:0]       out_smoothed_peak,
  input  logic                              cfg_we,
  input  logic [vub_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [vub_pkg::ALPHA_W-1:0]       cfg_wdata
);
  import vub_pkg::*;

  logic [ALPHA_W-1:0] att_r;
  logic [ALPHA_W-1:0] rel_r;
  logic [ALPHA_W-1:0] cfg_alpha;

  logic               accept;
  logic               s1_adv;
  logic               s1_valid_r;
  logic [1:0]         s1_cmd_r;
  logic [CHAN_W-1:0]  s1_chan_r;
  logic [LEVEL_W-1:0] s1_rms_r;
  logic [LEVEL_W-1:0] s1_peak_r;
  logic               s1_inrange_r;

  logic [LEVEL_W-1:0] old_rms;
  logic [LEVEL_W-1:0] old_peak;
  logic [ALPHA_W-1:0] rms_alpha;
  logic [LEVEL_W-1:0] trk_rms;
  logic [LEVEL_W-1:0] trk_peak;
  logic [LEVEL_W-1:0] new_rms;
  logic [LEVEL_W-1:0] wb_peak;
  logic               upd;
  vub_wr_t            wr;

  logic               out_valid_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic [LEVEL_W-1:0] out_rms_r;
  logic [LEVEL_W-1:0] out_peak_r;

  assign cfg_alpha = (cfg_wdata > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r <= ALPHA_ONE;
      rel_r <= ALPHA_ONE;
    end else if (cfg_we) begin
      if (cfg_addr == REG_ATTACK) begin
        att_r <= cfg_alpha;
      end
      if (cfg_addr == REG_RELEASE) begin
        rel_r <= cfg_alpha;
      end
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r     <= in_cmd;
      s1_chan_r    <= in_channel;
      s1_rms_r     <= in_rms_level;
      s1_peak_r    <= in_peak_level;
      s1_inrange_r <= (32'(in_channel) < NUM_CHANNELS);
    end
  end

  vub_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (ADDR_W'(in_channel)),
    .wr       (wr),
    .old_rms  (old_rms),
    .old_peak (old_peak)
  );

  assign rms_alpha = (s1_rms_r > old_rms) ? att_r : rel_r;

  vub_track u_trk_rms (
    .prev  (old_rms),
    .cur   (s1_rms_r),
    .alpha (rms_alpha),
    .next  (trk_rms)
  );

  vub_track u_trk_peak (
    .prev  (old_peak),
    .cur   (s1_peak_r),
    .alpha (rel_r),
    .next  (trk_peak)
  );

  always_comb begin
    upd      = 1'b0;
    new_rms  = old_rms;
    wb_peak  = old_peak;
    case (s1_cmd_r)
      CMD_SMOOTH: begin
        upd      = 1'b1;
        new_rms  = trk_rms;
        wb_peak  = (s1_peak_r > old_peak) ? s1_peak_r : trk_peak;
      end
      CMD_LOAD: begin
        upd      = 1'b1;
        new_rms  = s1_rms_r;
        wb_peak  = s1_peak_r;
      end
      default: begin
        upd = 1'b0;
      end
    endcase
    if (!s1_inrange_r) begin
      upd      = 1'b0;
      new_rms  = '0;
      wb_peak  = '0;
    end
  end

  always_comb begin
    wr.en   = s1_adv && upd;
    wr.addr = ADDR_W'(s1_chan_r);
    wr.rms  = new_rms;
    wr.peak = wb_peak;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_chan_r <= s1_chan_r;
      out_rms_r  <= new_rms;
      out_peak_r <= wb_peak;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_chan_r;
  assign out_smoothed_rms  = out_rms_r;
  assign out_smoothed_peak = out_peak_r;

`ifndef SYNTHESIS
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item missing from update stage");

  a_write_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (s1_adv && s1_inrange_r))
    else $error("store write without an advancing in-range item");

  a_advance_loads_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item missing from result register");

  a_stall_holds_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (s1_valid_r && $stable(s1_chan_r) && $stable(s1_rms_r)))
    else $error("update stage changed while stalled");
`endif

endmodule
